// ===== src/radix_ascii_formatter_macros.svh =====
// ----------------------------------------------------------------------------
// radix_ascii_formatter_macros
// assertion macros used by the formatter rtl
// ----------------------------------------------------------------------------
`ifndef RADIX_ASCII_FORMATTER_MACROS_SVH
`define RADIX_ASCII_FORMATTER_MACROS_SVH

// same-cycle implication
`define RAF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("formatter assertion failed");

// next-cycle implication
`define RAF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("formatter assertion failed");

`endif

// ===== src/raf_pkg.sv =====
// ----------------------------------------------------------------------------
// raf_pkg
// constants, types and digit encoding for the radix ascii formatter
// ----------------------------------------------------------------------------
package raf_pkg;

  localparam logic [1:0] MODE_HEX     = 2'd0;
  localparam logic [1:0] MODE_DEC     = 2'd1;
  localparam logic [1:0] MODE_BIN     = 2'd2;
  localparam logic [1:0] MODE_BIN_ALT = 2'd3;

  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam logic [7:0] ASCII_NINE    = 8'd57;
  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_UPPER_F = 8'd70;

  localparam logic [3:0] DEC_BASE   = 4'd10;
  localparam logic [3:0] DAB_THRESH = 4'd5;
  localparam logic [3:0] DAB_ADJ    = 4'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [3:0] ofs;
    ofs = d - DEC_BASE;
    if (d < DEC_BASE) begin
      return ASCII_ZERO + {4'd0, d};
    end else begin
      return ASCII_UPPER_A + {4'd0, ofs};
    end
  endfunction

endpackage

// ===== src/raf_dabble.sv =====
// ----------------------------------------------------------------------------
// raf_dabble
// bit-serial binary to bcd converter, shift-and-add-3, one bit per cycle
// ----------------------------------------------------------------------------
module raf_dabble #(
  parameter int VALUE_WIDTH = 64,
  parameter int DEC_DIGITS  = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [VALUE_WIDTH-1:0]      value,
  output logic [4*DEC_DIGITS-1:0]     bcd,
  output raf_pkg::dab_stat_t          stat
);
  import raf_pkg::*;

  localparam int BW = 4 * DEC_DIGITS;
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] sh_r;
  logic [BW-1:0]          bcd_r;
  logic [BW-1:0]          adj;
  logic [BW-1:0]          bcd_nxt;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;

  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= DAB_THRESH) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + DAB_ADJ;
      end
    end
    bcd_nxt = {adj[BW-2:0], sh_r[VALUE_WIDTH-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        sh_r   <= value;
        bcd_r  <= '0;
        cnt_r  <= CW'(VALUE_WIDTH);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        sh_r  <= sh_r << 1;
        bcd_r <= bcd_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign bcd       = bcd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== src/radix_ascii_formatter.sv =====
// sequence: hex and binary load the value on accept and then emit digit
// positions msd first, skipping leading zero positions but never the last one;
// decimal first runs bit-serial bcd conversion in raf_dabble and hands the
// result over before emission; a new value is accepted only in idle, once the
// last digit of the previous value has been issued
// reset: synchronous active-low rst_n clears the fsm and output valid
// ----------------------------------------------------------------------------
// radix_ascii_formatter
// formats an unsigned value as hex, decimal or binary ascii, msd first
// ----------------------------------------------------------------------------
module radix_ascii_formatter #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_code,
  output logic        out_last
);
  import raf_pkg::*;
  `include "radix_ascii_formatter_macros.svh"

  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int HEX_W      = 4 * HEX_DIGITS;
  localparam int DEC_W      = 4 * DEC_DIGITS;
  localparam int EW         = (HEX_W > DEC_W) ? HEX_W : DEC_W;
  localparam int NW         = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                 state_r;
  logic [1:0]             mode_r;
  logic [EW-1:0]          emit_r;
  logic [NW-1:0]          ndig_r;
  logic                   started_r;
  logic                   out_valid_r;
  logic [7:0]             out_char_r;
  logic                   out_last_r;

  logic [VALUE_WIDTH-1:0] val;
  logic [DEC_W-1:0]       bcd;
  dab_stat_t              dab_stat;
  logic                   dab_start;
  logic                   is_bin;
  logic [3:0]             top_digit;
  logic [EW-1:0]          emit_shift;
  logic                   slot_free;
  logic                   skip;

  assign val       = in_value[VALUE_WIDTH-1:0];
  assign in_ready  = (state_r == ST_IDLE);
  assign dab_start = in_valid && in_ready && (in_mode == MODE_DEC);

  raf_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DEC_DIGITS  (DEC_DIGITS)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .value (val),
    .bcd   (bcd),
    .stat  (dab_stat)
  );

  always_comb begin
    unique case (mode_r) inside
      MODE_BIN, MODE_BIN_ALT: is_bin = 1'b1;
      default:                is_bin = 1'b0;
    endcase
    top_digit  = is_bin ? {3'b000, emit_r[EW-1]} : emit_r[EW-1 -: 4];
    emit_shift = is_bin ? (emit_r << 1) : (emit_r << 4);
    slot_free  = !out_valid_r || out_ready;
    skip       = !started_r && (top_digit == 4'd0) && (ndig_r != NW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mode_r    <= in_mode;
            started_r <= 1'b0;
            unique case (in_mode) inside
              MODE_HEX: begin
                emit_r  <= EW'(val) << (EW - HEX_W);
                ndig_r  <= NW'(HEX_DIGITS);
                state_r <= ST_EMIT;
              end
              MODE_DEC: begin
                state_r <= ST_CONV;
              end
              MODE_BIN, MODE_BIN_ALT: begin
                emit_r  <= EW'(val) << (EW - VALUE_WIDTH);
                ndig_r  <= NW'(VALUE_WIDTH);
                state_r <= ST_EMIT;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CONV: begin
          if (dab_stat.done) begin
            emit_r  <= EW'(bcd) << (EW - DEC_W);
            ndig_r  <= NW'(DEC_DIGITS);
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip) begin
            emit_r <= emit_shift;
            ndig_r <= ndig_r - 1'b1;
          end else if (slot_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= digit_char(top_digit);
            out_last_r  <= (ndig_r == NW'(1));
            started_r   <= 1'b1;
            emit_r      <= emit_shift;
            ndig_r      <= ndig_r - 1'b1;
            if (ndig_r == NW'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  `RAF_ASSERT_IMP(a_char_is_digit, clk, rst_n, out_valid,
    ((out_char_code >= ASCII_ZERO) && (out_char_code <= ASCII_NINE)) ||
    ((out_char_code >= ASCII_UPPER_A) && (out_char_code <= ASCII_UPPER_F)))
  `RAF_ASSERT_IMP(a_emit_has_digits, clk, rst_n, state_r == ST_EMIT, ndig_r != '0)
  `RAF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `RAF_ASSERT_IMP(a_conv_tracks_dabble, clk, rst_n, state_r == ST_CONV,
    dab_stat.busy || dab_stat.done)

endmodule
